/* hw/rtl/dual_timebase_timestamp_unit_macros.svh */
// Assertion macros shared by the timestamp unit RTL.
// Each macro expects clk_i and rst_ni to exist in the calling module.
`ifndef DUAL_TIMEBASE_TIMESTAMP_UNIT_MACROS_SVH
`define DUAL_TIMEBASE_TIMESTAMP_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge out of reset.
`define DTTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A consequence that must hold in the same cycle as its antecedent.
`define DTTS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
// A consequence that must hold in the cycle after its antecedent.
`define DTTS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define DTTS_ASSERT(lbl, prop, msg)
`define DTTS_IMPLY(lbl, ante, cons, msg)
`define DTTS_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/dtts_pkg.sv */
`default_nettype none

package dtts_pkg;

  // Event codes carried in the kind field of an input item.
  typedef enum logic [2:0] {
    KIND_RESYNC   = 3'd0,
    KIND_OVERFLOW = 3'd1,
    KIND_READ     = 3'd2,
    KIND_SLEEP    = 3'd3,
    KIND_FAST     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] slow_count;
    logic [15:0] fast_count;
    logic [31:0] wake_target;
  } dtts_in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        used_fallback;
    logic        out_of_range;
  } dtts_out_t;

  // Per-stage tag: valid marks an item that yields a result, sleep marks an item whose
  // value still has to come out of the divider.
  typedef struct packed {
    logic      valid;
    logic      sleep;
    dtts_out_t res;
  } dtts_pipe_t;

  // Slow ticks to microseconds: (slow * 1000000 + 8192) >> 14.
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam logic [51:0] SLOW_ROUND = 52'd8192;
  localparam int          SLOW_SHIFT = 14;

  localparam logic [31:0] FAST_LIMIT = 32'h0000_ffff;

  // Sleep conversion: ((ext << 14) + 500000) >> 6 equals ((ext << 8) + 7812) because the
  // low six bits never carry. 7812 splits into 30 above bit 8 and 0x84 below it.
  localparam logic [49:0] EXT_ROUND_HI = 50'd30;
  localparam logic [7:0]  EXT_ROUND_LO = 8'h84;

  // Remaining divisor 1000000 / 64 = 15625, handled 16 quotient bits at a time.
  // DIV_RECIP = ceil(2^44 / 15625) gives exact quotients for dividends below 2^30.
  localparam logic [13:0] DIV_DIGIT   = 14'd15625;
  localparam logic [30:0] DIV_RECIP   = 31'd1125899907;
  localparam int          RECIP_SHIFT = 44;

  function automatic logic [15:0] div_digit_q(input logic [29:0] x);
    logic [60:0] prod;
    prod = 61'(x) * 61'(DIV_RECIP);
    return prod[RECIP_SHIFT +: 16];
  endfunction

  function automatic logic [13:0] div_digit_r(input logic [29:0] x, input logic [15:0] q);
    logic [29:0] rem;
    rem = x - 30'(q) * 30'(DIV_DIGIT);
    return rem[13:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dual_timebase_timestamp_unit.sv */
// Channel   Direction  Payload               Handshake
// -------   ---------  --------------------  ----------------------
// in        input      dtts_pkg::dtts_in_t   in_valid_i / in_ready_o
// out       output     dtts_pkg::dtts_out_t  out_valid_o / out_ready_i
//
// One item is accepted per cycle while in_ready_o is high. The pipeline depth is set by the
// sleep conversion, a division by 15625 done as three 16-bit digits: the first two each a
// reciprocal multiply followed by a remainder multiply, the last a reciprocal multiply only.
// Reset clears all timebase state at once; there is no clearing pass.
// A two-entry output buffer absorbs a stalled consumer, and in_ready_o drops only once both
// entries are full. Items without a result leave a bubble and never reach the output.
`default_nettype none

module dual_timebase_timestamp_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtts_pkg::dtts_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtts_pkg::dtts_out_t out_data_o
);

  // The whole pipeline advances together; it holds only while the output buffer is full.
  logic                 pipe_en;
  dtts_pkg::dtts_pipe_t front_pipe;
  logic [57:0]          front_m;
  logic                 div_valid;
  dtts_pkg::dtts_out_t  div_data;

  assign in_ready_o = pipe_en;

  // Input register, timebase state, slow-to-microsecond conversion and the timestamp and
  // fast compare results.
  dtts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .pipe_o     (front_pipe),
    .m_o        (front_m)
  );

  // Sleep target to slow ticks. Other results ride along unchanged to keep item order.
  dtts_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .pipe_i      (front_pipe),
    .m_i         (front_m),
    .out_valid_o (div_valid),
    .out_data_o  (div_data)
  );

  // Output register with a skid entry.
  dtts_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_data_i   (div_data),
    .in_ready_o  (pipe_en),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

endmodule

`default_nettype wire

/* hw/rtl/dtts_front.sv */
`default_nettype none

`include "dual_timebase_timestamp_unit_macros.svh"

module dtts_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  dtts_pkg::dtts_in_t   in_data_i,
  output dtts_pkg::dtts_pipe_t pipe_o,
  output logic [57:0]          m_o
);

  logic               s1_valid_q;
  dtts_pkg::dtts_in_t s1_q;

  logic        s2_valid_q;
  logic [2:0]  s2_kind_q;
  logic [51:0] s2_prod_q;
  logic [15:0] s2_fast_q;
  logic [31:0] s2_target_q;
  logic [49:0] s2_ext_hi_q;

  logic [31:0] wrap_q, wrap_d;
  logic [31:0] last_q, last_d;
  logic [31:0] base_q, base_d;
  logic [15:0] sync_q, sync_d;
  logic        tout_q, tout_d;

  logic [51:0] slow_prod;
  logic [31:0] wrap_new;
  logic [51:0] conv_sum;
  logic [31:0] conv;
  logic [31:0] read_ts;
  logic [31:0] fast_cmp;

  // Stage one: slow conversion product and the wrap count of sleep targets.
  assign slow_prod = 52'(s1_q.slow_count) * 52'(dtts_pkg::US_PER_SEC);
  assign wrap_new  = wrap_q + 32'(s1_q.wake_target < last_q);

  always_comb begin
    wrap_d = wrap_q;
    last_d = last_q;
    if (en_i && s1_valid_q && s1_q.kind == dtts_pkg::KIND_SLEEP) begin
      wrap_d = wrap_new;
      last_d = s1_q.wake_target;
    end
  end

  // Stage two: rounding, timebase state and the results that need no division.
  assign conv_sum = s2_prod_q + dtts_pkg::SLOW_ROUND;
  assign conv     = conv_sum[dtts_pkg::SLOW_SHIFT +: 32];
  assign read_ts  = 32'(s2_fast_q) - 32'(sync_q) + base_q;
  assign fast_cmp = s2_target_q - base_q + 32'(sync_q);
  assign m_o      = {s2_ext_hi_q + dtts_pkg::EXT_ROUND_HI, dtts_pkg::EXT_ROUND_LO};

  always_comb begin
    base_d = base_q;
    sync_d = sync_q;
    tout_d = tout_q;
    pipe_o = '0;
    unique case (s2_kind_q)
      dtts_pkg::KIND_RESYNC: begin
        if (en_i && s2_valid_q) begin
          sync_d = s2_fast_q;
          base_d = conv;
          tout_d = 1'b0;
        end
      end
      dtts_pkg::KIND_OVERFLOW: begin
        if (en_i && s2_valid_q) begin
          tout_d = 1'b1;
        end
      end
      dtts_pkg::KIND_READ: begin
        pipe_o.valid             = s2_valid_q;
        pipe_o.res.value         = tout_q ? conv : read_ts;
        pipe_o.res.used_fallback = tout_q;
      end
      dtts_pkg::KIND_SLEEP: begin
        pipe_o.valid = s2_valid_q;
        pipe_o.sleep = 1'b1;
      end
      dtts_pkg::KIND_FAST: begin
        pipe_o.valid            = s2_valid_q;
        pipe_o.res.value        = fast_cmp;
        pipe_o.res.out_of_range = (fast_cmp >= dtts_pkg::FAST_LIMIT);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_kind_q  <= dtts_pkg::KIND_RESYNC;
      wrap_q     <= '0;
      last_q     <= '0;
      base_q     <= '0;
      sync_q     <= '0;
      tout_q     <= 1'b0;
    end else begin
      if (en_i) begin
        s1_valid_q <= in_valid_i;
        s2_valid_q <= s1_valid_q;
        s2_kind_q  <= s1_q.kind;
      end
      wrap_q <= wrap_d;
      last_q <= last_d;
      base_q <= base_d;
      sync_q <= sync_d;
      tout_q <= tout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q        <= in_data_i;
      s2_prod_q   <= slow_prod;
      s2_fast_q   <= s1_q.fast_count;
      s2_target_q <= s1_q.wake_target;
      s2_ext_hi_q <= {wrap_new[17:0], s1_q.wake_target};
    end
  end

  `DTTS_ASSERT(a_wrap_step, (wrap_q == $past(wrap_q)) || (wrap_q == $past(wrap_q) + 32'd1), "wrap count moved by more than one")

endmodule

`default_nettype wire

/* hw/rtl/dtts_div.sv */
`default_nettype none

`include "dual_timebase_timestamp_unit_macros.svh"

module dtts_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  dtts_pkg::dtts_pipe_t pipe_i,
  input  logic [57:0]          m_i,
  output logic                 out_valid_o,
  output dtts_pkg::dtts_out_t  out_data_o
);

  localparam int Stages = 6;

  dtts_pkg::dtts_pipe_t pipe_q [Stages];

  logic [57:0] m_q;
  logic [15:0] q1_q;
  logic [25:0] x1_q;
  logic [31:0] lo2_q;
  logic [29:0] x2_q;
  logic [15:0] lo3_q;
  logic [15:0] q2_q;
  logic [29:0] x2b_q;
  logic [15:0] lo4_q;
  logic [29:0] x3_q;
  logic [15:0] q2c_q;
  logic [15:0] q3_q;
  logic [15:0] q2d_q;

  // Long division of the 58-bit dividend by 15625 in 16-bit digits. The top ten bits are
  // below the divisor, so they start out as the first partial remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= m_i;
      q1_q  <= dtts_pkg::div_digit_q(30'(m_q[57:32]));
      x1_q  <= m_q[57:32];
      lo2_q <= m_q[31:0];
      x2_q  <= {dtts_pkg::div_digit_r(30'(x1_q), q1_q), lo2_q[31:16]};
      lo3_q <= lo2_q[15:0];
      q2_q  <= dtts_pkg::div_digit_q(x2_q);
      x2b_q <= x2_q;
      lo4_q <= lo3_q;
      x3_q  <= {dtts_pkg::div_digit_r(x2b_q, q2_q), lo4_q};
      q2c_q <= q2_q;
      q3_q  <= dtts_pkg::div_digit_q(x3_q);
      q2d_q <= q2c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Stages; i++) begin
        pipe_q[i] <= '0;
      end
    end else if (en_i) begin
      pipe_q[0] <= pipe_i;
      for (int i = 1; i < Stages; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  // Only the low 32 quotient bits are kept.
  always_comb begin
    out_data_o = pipe_q[Stages-1].res;
    if (pipe_q[Stages-1].sleep) begin
      out_data_o.value = {q2d_q, q3_q};
    end
  end

  assign out_valid_o = pipe_q[Stages-1].valid;

  `DTTS_IMPLY(a_rem_mid, pipe_q[2].valid && pipe_q[2].sleep, x2_q[29:16] < dtts_pkg::DIV_DIGIT, "middle digit remainder out of range")
  `DTTS_IMPLY(a_rem_low, pipe_q[4].valid && pipe_q[4].sleep, x3_q[29:16] < dtts_pkg::DIV_DIGIT, "low digit remainder out of range")

endmodule

`default_nettype wire

/* hw/rtl/dtts_skid.sv */
`default_nettype none

`include "dual_timebase_timestamp_unit_macros.svh"

module dtts_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  dtts_pkg::dtts_out_t in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output dtts_pkg::dtts_out_t out_data_o,
  input  logic                out_ready_i
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  dtts_pkg::dtts_out_t out_q, out_d;
  dtts_pkg::dtts_out_t skid_q, skid_d;
  logic                take;
  logic                push;

  assign in_ready_o = !skid_valid_q;
  assign take       = out_valid_q && out_ready_i;
  assign push       = in_valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || take) begin
        out_d       = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DTTS_IMPLY(a_skid_behind_out, skid_valid_q, out_valid_q, "skid entry held without an output entry")
  `DTTS_NEXT(a_skid_drains, skid_valid_q && out_ready_i, !skid_valid_q, "skid entry not drained")

endmodule

`default_nettype wire

/* dv/dual_timebase_timestamp_unit_tb.sv */
`default_nettype none

module dual_timebase_timestamp_unit_tb;

  // Three pacing regimes, in the order the run goes through them. The first
  // starves the block of output bandwidth, the second starves it of input,
  // and the last runs both channels flat out.
  typedef enum int {
    PACE_SENDER_SLOW,
    PACE_RECEIVER_SLOW,
    PACE_FULL_RATE
  } pace_e;

  // One entry of the stimulus queue. Besides the item itself it carries the
  // pacing regime it belongs to and two flags: drain_first keeps the item
  // back until every outstanding result has arrived, and hold_out makes the
  // consumer stall for a long stretch once the item has been accepted.
  typedef struct {
    dtts_pkg::dtts_in_t ev;
    pace_e              pace;
    bit                 drain_first;
    bit                 hold_out;
  } event_slot_t;

  localparam int unsigned RANDOM_ITEMS  = 1400;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam logic [2:0]  KIND_SPARE_LAST = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  dtts_pkg::dtts_in_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  dtts_pkg::dtts_out_t out_data_o;

  dual_timebase_timestamp_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  event_slot_t         pending_events[$];
  dtts_pkg::dtts_out_t expected_results[$];
  int unsigned         mismatch_count = 0;

  // Shadow copy of the timebase state, advanced once per accepted item.
  logic [31:0] shadow_time_base   = '0;
  logic [15:0] shadow_capture     = '0;
  logic        shadow_timed_out   = 1'b0;
  logic [31:0] shadow_last_target = '0;
  logic [31:0] shadow_wrap_count  = '0;

  // Bookkeeping of the stimulus generator.
  int unsigned counted_items = 0;
  pace_e       gen_pace      = PACE_SENDER_SLOW;

  // Handshake-side state shared between driver and consumer.
  pace_e       cur_pace      = PACE_SENDER_SLOW;
  logic        offered_hold  = 1'b0;
  logic        hold_go       = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Slow ticks to microseconds, rounded to nearest: (slow * 10^6 + 8192) / 2^14,
  // keeping the low 32 bits of the quotient.
  function automatic logic [31:0] us_from_slow(input logic [31:0] slow);
    logic [63:0] scaled;
    scaled = 64'(slow) * 64'd1000000 + 64'd8192;
    return scaled[45:14];
  endfunction

  function automatic int unsigned sender_idle_pct(input pace_e pace);
    case (pace)
      PACE_SENDER_SLOW:   return 32;
      PACE_RECEIVER_SLOW: return 75;
      default:            return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct(input pace_e pace);
    case (pace)
      PACE_SENDER_SLOW:   return 75;
      PACE_RECEIVER_SLOW: return 32;
      default:            return 0;
    endcase
  endfunction

  // Advances the shadow state by one accepted item and queues the result it
  // should produce, if any. Resync and overflow update state silently, and
  // the three spare kinds are dropped without touching anything.
  task automatic predict_event(input dtts_pkg::dtts_in_t ev);
    dtts_pkg::dtts_out_t res;
    logic [63:0]         extended;
    res = '0;
    case (ev.kind)
      dtts_pkg::KIND_RESYNC: begin
        shadow_capture   = ev.fast_count;
        shadow_time_base = us_from_slow(ev.slow_count);
        shadow_timed_out = 1'b0;
      end
      dtts_pkg::KIND_OVERFLOW: begin
        shadow_timed_out = 1'b1;
      end
      dtts_pkg::KIND_READ: begin
        // Once the fast counter has overflowed, the capture is stale and the
        // timestamp falls back to converting the slow count directly.
        if (shadow_timed_out) begin
          res.value         = us_from_slow(ev.slow_count);
          res.used_fallback = 1'b1;
        end else begin
          res.value = {16'h0, ev.fast_count} - {16'h0, shadow_capture} + shadow_time_base;
        end
        expected_results.push_back(res);
      end
      dtts_pkg::KIND_SLEEP: begin
        // A target below the previous one means the microsecond clock wrapped.
        if (ev.wake_target < shadow_last_target) begin
          shadow_wrap_count = shadow_wrap_count + 32'd1;
        end
        shadow_last_target = ev.wake_target;
        extended  = {shadow_wrap_count, ev.wake_target};
        extended  = extended * 64'd16384 + 64'd500000;
        extended  = extended / 64'd1000000;
        res.value = extended[31:0];
        expected_results.push_back(res);
      end
      dtts_pkg::KIND_FAST: begin
        res.value        = ev.wake_target - shadow_time_base + {16'h0, shadow_capture};
        res.out_of_range = (res.value >= dtts_pkg::FAST_LIMIT);
        expected_results.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // Appends one item to the stimulus queue. The pacing regime follows from how
  // many meaningful items have been queued so far. The first item of each new
  // regime waits for the pipeline to drain, and the first item of the full
  // rate regime also triggers the long consumer stall.
  task automatic queue_event(input logic [2:0] kind, input logic [31:0] slow,
                             input logic [15:0] fast, input logic [31:0] target);
    event_slot_t slot;
    pace_e       pace;
    if (counted_items < RANDOM_ITEMS / 3) begin
      pace = PACE_SENDER_SLOW;
    end else if (counted_items < 2 * RANDOM_ITEMS / 3) begin
      pace = PACE_RECEIVER_SLOW;
    end else begin
      pace = PACE_FULL_RATE;
    end
    slot.ev.kind        = kind;
    slot.ev.slow_count  = slow;
    slot.ev.fast_count  = fast;
    slot.ev.wake_target = target;
    slot.pace           = pace;
    slot.drain_first    = (pace != gen_pace);
    slot.hold_out       = (pace != gen_pace) && (pace == PACE_FULL_RATE);
    gen_pace            = pace;
    pending_events.push_back(slot);
    if (kind <= dtts_pkg::KIND_FAST) begin
      counted_items++;
    end
  endtask

  // Driver. An offered item stays on the bus until it is accepted; the next
  // one is taken from the queue in the same cycle unless the sender decides
  // to idle or the head item waits for the pipeline to drain. Every signal
  // gets exactly one assignment per edge so back-to-back items never glitch.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    event_slot_t        head;
    logic               next_valid;
    dtts_pkg::dtts_in_t next_data;
    logic               next_hold_go;
    logic               next_offered_hold;
    pace_e              next_pace;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_data_i    <= '0;
      hold_go      <= 1'b0;
      offered_hold <= 1'b0;
      cur_pace     <= PACE_SENDER_SLOW;
    end else begin
      next_valid        = in_valid_i;
      next_data         = in_data_i;
      next_hold_go      = 1'b0;
      next_offered_hold = offered_hold;
      next_pace         = cur_pace;
      if (in_valid_i && in_ready_o) begin
        predict_event(in_data_i);
        next_hold_go = offered_hold;
        next_valid   = 1'b0;
      end
      if (!next_valid && pending_events.size() != 0) begin
        head = pending_events[0];
        if ((!head.drain_first || expected_results.size() == 0) &&
            $urandom_range(99) >= sender_idle_pct(head.pace)) begin
          void'(pending_events.pop_front());
          next_valid        = 1'b1;
          next_data         = head.ev;
          next_offered_hold = head.hold_out;
          next_pace         = head.pace;
        end
      end
      in_valid_i   <= next_valid;
      in_data_i    <= next_data;
      hold_go      <= next_hold_go;
      offered_hold <= next_offered_hold;
      cur_pace     <= next_pace;
    end
  end

  // Consumer. Ready toggles at random according to the current regime, except
  // during the long stall, which is counted down here so that the sender
  // keeps offering items and the output buffer and the pipeline fill up.
  always @(posedge clk_i or negedge rst_ni) begin : accept_results
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (hold_go) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct(cur_pace));
    end
  end

  // Result checker: every accepted result is matched against the oldest
  // outstanding prediction, field by field.
  always @(posedge clk_i) begin : check_results
    dtts_pkg::dtts_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding, value", out_data_o.value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.value !== want.value) begin
          report_mismatch("value", out_data_o.value, want.value);
        end
        if (out_data_o.used_fallback !== want.used_fallback) begin
          report_mismatch("used_fallback", 32'(out_data_o.used_fallback),
                          32'(want.used_fallback));
        end
        if (out_data_o.out_of_range !== want.out_of_range) begin
          report_mismatch("out_of_range", 32'(out_data_o.out_of_range),
                          32'(want.out_of_range));
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake on either channel means
  // the block has hung.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("** dual_timebase_timestamp_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned pick;
    int unsigned steps;
    int unsigned k;
    logic [31:0] slow;
    logic [15:0] cap;
    logic [31:0] base;
    logic [31:0] target;
    logic [31:0] sleep_last;

    // Directed part. Out of reset the base and capture are zero, so reads
    // return the raw fast count.
    queue_event(dtts_pkg::KIND_READ, 32'h0, 16'h0000, 32'h0);
    queue_event(dtts_pkg::KIND_READ, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    // Sleep targets: zero, the top of the range, then a wrap back to zero.
    queue_event(dtts_pkg::KIND_SLEEP, 32'h0, 16'h0, 32'h0000_0000);
    queue_event(dtts_pkg::KIND_SLEEP, 32'h0, 16'h0, 32'hffff_ffff);
    queue_event(dtts_pkg::KIND_SLEEP, 32'h0, 16'h0, 32'h0000_0000);
    // Fast compare on both sides of the range limit.
    queue_event(dtts_pkg::KIND_FAST, 32'h0, 16'h0, 32'h0000_0000);
    queue_event(dtts_pkg::KIND_FAST, 32'h0, 16'h0, 32'h0000_fffe);
    queue_event(dtts_pkg::KIND_FAST, 32'h0, 16'h0, 32'h0000_ffff);
    // Resync at the largest slow count and capture; a read below the capture
    // and a fast compare that wraps around.
    queue_event(dtts_pkg::KIND_RESYNC, 32'hffff_ffff, 16'hffff, 32'h0);
    queue_event(dtts_pkg::KIND_READ, 32'h0, 16'h0000, 32'h0);
    queue_event(dtts_pkg::KIND_FAST, 32'h0, 16'h0, 32'h0000_0000);
    queue_event(dtts_pkg::KIND_FAST, 32'h0, 16'h0, 32'hffff_ffff);
    // After an overflow, reads fall back to the slow count at both extremes.
    queue_event(dtts_pkg::KIND_OVERFLOW, 32'h0, 16'h0, 32'h0);
    queue_event(dtts_pkg::KIND_READ, 32'h0000_0000, 16'h1234, 32'h0);
    queue_event(dtts_pkg::KIND_READ, 32'hffff_ffff, 16'h1234, 32'h0);
    // The spare kinds must leave the timed-out state untouched.
    for (k = dtts_pkg::KIND_FAST + 1; k <= KIND_SPARE_LAST; k++) begin
      queue_event(3'(k), 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    end
    queue_event(dtts_pkg::KIND_READ, 32'h0000_4000, 16'h0, 32'h0);
    // A resync clears the timeout again.
    queue_event(dtts_pkg::KIND_RESYNC, 32'h0, 16'h0000, 32'hffff_ffff);
    queue_event(dtts_pkg::KIND_READ, 32'hffff_ffff, 16'hffff, 32'h0);
    queue_event(dtts_pkg::KIND_FAST, 32'h0, 16'h0, 32'h0000_fffe);

    // Random part. Most of it is resync episodes followed by requests whose
    // operands sit close to the current timebase, so that reads land near the
    // capture, fast compares straddle the range limit and sleep targets grow
    // steadily with an occasional wrap. The rest is unstructured noise.
    sleep_last = '0;
    while (counted_items < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        queue_event(3'($urandom_range(KIND_SPARE_LAST)), $urandom, 16'($urandom), $urandom);
      end else begin
        slow = (roll < 30) ? 32'($urandom_range(2000)) : 32'($urandom);
        cap  = 16'($urandom);
        base = us_from_slow(slow);
        queue_event(dtts_pkg::KIND_RESYNC, slow, cap, $urandom);
        steps = $urandom_range(2, 8);
        for (k = 0; k < steps; k++) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            queue_event(dtts_pkg::KIND_OVERFLOW, $urandom, 16'($urandom), $urandom);
          end else if (pick < 45) begin
            if ($urandom_range(1) == 0) begin
              queue_event(dtts_pkg::KIND_READ, $urandom,
                          cap + 16'($urandom_range(4000)), $urandom);
            end else begin
              queue_event(dtts_pkg::KIND_READ, $urandom, 16'($urandom), $urandom);
            end
          end else if (pick < 70) begin
            if ($urandom_range(9) == 0) begin
              target = $urandom;
            end else begin
              target = sleep_last + 32'($urandom_range(32'h0100_0000));
            end
            sleep_last = target;
            queue_event(dtts_pkg::KIND_SLEEP, $urandom, 16'($urandom), target);
          end else begin
            // Offsets around 0xffff from the current base hit the range edge.
            if (pick >= 95) begin
              target = base - {16'h0, cap} + 32'($urandom_range(32'hfffe, 32'h10000));
            end else if (pick >= 90) begin
              target = $urandom;
            end else begin
              target = base - {16'h0, cap} + 32'($urandom_range(32'h1ffff));
            end
            queue_event(dtts_pkg::KIND_FAST, $urandom, 16'($urandom), target);
          end
        end
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let the driver empty the queue and the block deliver every result, then
    // allow a few more cycles for anything the block should not have sent.
    while (pending_events.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered, count", 32'(expected_results.size()), '0);
    end
    if (mismatch_count == 0) begin
      $display("** dual_timebase_timestamp_unit: PASSED **");
    end else begin
      $display("** dual_timebase_timestamp_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dtts_pkg.sv
hw/rtl/dtts_front.sv
hw/rtl/dtts_div.sv
hw/rtl/dtts_skid.sv
hw/rtl/dual_timebase_timestamp_unit.sv
dv/dual_timebase_timestamp_unit_tb.sv
